FILE: hdl/checksummed_frame_parser_macros.svh
// ----------------------------------------------------------------------------
// checksummed frame parser assertion macros
// shared property wrappers, clocked on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef CHECKSUMMED_FRAME_PARSER_MACROS_SVH
`define CHECKSUMMED_FRAME_PARSER_MACROS_SVH

// condition that must hold at every clock edge
`define CKFP_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("checksummed_frame_parser: invariant violated");

// antecedent implies consequent in the same cycle
`define CKFP_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("checksummed_frame_parser: implication violated");

`endif

FILE: hdl/ckfp_pkg.sv
// ----------------------------------------------------------------------------
// ckfp_pkg
// types and constants of the checksummed frame parser
// ----------------------------------------------------------------------------
package ckfp_pkg;

   localparam int MAX_PAYLOAD = 512;
   localparam int LEN_W       = 10;
   localparam int POS_W       = 10;
   localparam int HDR_POS_W   = 3;

   // header byte positions
   localparam logic [HDR_POS_W-1:0] HDR_SEQ_LO  = 3'd1;
   localparam logic [HDR_POS_W-1:0] HDR_LEN_LO  = 3'd2;
   localparam logic [HDR_POS_W-1:0] HDR_LEN_END = 3'd5;
   localparam logic [HDR_POS_W-1:0] HDR_EOT     = 3'd6;
   localparam logic [HDR_POS_W-1:0] HDR_LAST    = 3'd7;

   typedef enum logic [2:0] {
      KIND_HEADER    = 3'd0,
      KIND_PAYLOAD   = 3'd1,
      KIND_GOOD      = 3'd2,
      KIND_BAD       = 3'd3,
      KIND_TOO_LARGE = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      PHASE_HEADER  = 2'd0,
      PHASE_PAYLOAD = 2'd1,
      PHASE_CHECK   = 2'd2
   } phase_type;

endpackage

FILE: hdl/checksummed_frame_parser.sv
// ----------------------------------------------------------------------------
// checksummed_frame_parser
// byte-wide parser for length-prefixed frames with a ones'-complement checksum
// ----------------------------------------------------------------------------
// usage
//   req channel: one frame byte per word, in wire order
//   rsp channel: exactly one result word per request word, carrying the kind
//     (header/check byte, payload byte, frame good, checksum bad, length too
//     large), the payload byte and the header fields seen so far
//   rsp_tlast marks the word that ends a frame (good, bad or too large)
//   path: a request word goes through the input register, then the result
//     register, with the parser state update in between
//   throughput: one word per cycle, sustained while rsp_tready stays high;
//     the single-pass update of sum, counters and header fields sets it
//   stall: when rsp_tready is low the result register holds, the input
//     register fills, then req_tready drops; no word is lost or repeated
//   reset: synchronous, clears the valid flags of both registers and the
//     parser state, and the parser then expects the first header byte
//   a length above the limit ends the frame at its sixth byte, and the next
//   byte is taken as the start of a new header
// ----------------------------------------------------------------------------
`include "checksummed_frame_parser_macros.svh"

module checksummed_frame_parser
   import ckfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_in
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] payload_byte, [23:8] sequence_number,
                                    // [33:24] payload_length, [34] end_of_transmission,
                                    // [39:35] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // last
);

   // input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;

   // result register
   logic              out_valid_ff;
   kind_type          out_kind_ff,  out_kind_in;
   logic [7:0]        out_pay_ff,   out_pay_in;
   logic [15:0]       out_seq_ff;
   logic [LEN_W-1:0]  out_len_ff,   out_len_in;
   logic              out_eot_ff;
   logic              out_last_ff,  out_last_in;

   // parser state
   phase_type         phase_ff,     phase_in;
   logic [POS_W-1:0]  byte_pos_ff,  byte_pos_in;
   logic [15:0]       held_seq_ff,  held_seq_in;
   logic [31:0]       held_len_ff,  held_len_in;
   logic              held_eot_ff,  held_eot_in;
   logic [15:0]       sum_ff,       sum_in;
   logic [7:0]        pend_ff,      pend_in;
   logic [7:0]        check_hi_ff,  check_hi_in;

   logic advance;
   logic step;

   // the result register frees up when empty or taken this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
   end

   // parser step on the registered byte
   always_comb begin
      logic [HDR_POS_W-1:0] p;
      logic [15:0]          sum_base;
      logic [16:0]          sum_wide;
      logic [15:0]          sum_pair;
      logic [POS_W-1:0]     pos_inc;
      logic                 odd;
      logic [7:0]           b;

      b        = in_byte_ff;
      p        = byte_pos_ff[HDR_POS_W-1:0];
      phase_in    = phase_ff;
      byte_pos_in = byte_pos_ff;
      held_seq_in = held_seq_ff;
      held_len_in = held_len_ff;
      held_eot_in = held_eot_ff;
      sum_in      = sum_ff;
      pend_in     = pend_ff;
      check_hi_in = check_hi_ff;
      out_kind_in = KIND_HEADER;
      out_pay_in  = 8'd0;
      out_last_in = 1'b0;
      pos_inc     = byte_pos_ff + POS_W'(1);
      odd         = 1'b0;
      sum_base    = sum_ff;

      unique case (phase_ff)
         PHASE_HEADER: begin
            // frame start clears the length, eot and sum
            if (p == '0) begin
               held_len_in = '0;
               held_eot_in = 1'b0;
               sum_base    = '0;
            end
            odd = p[0];
            if (p <= HDR_SEQ_LO) begin
               held_seq_in = {held_seq_ff[7:0], b};
            end else if (p <= HDR_LEN_END) begin
               held_len_in = {held_len_in[23:0], b};
            end else if (p == HDR_EOT) begin
               held_eot_in = (b == 8'd0);
            end
            byte_pos_in = POS_W'(p) + POS_W'(1);
            if (p == HDR_LEN_END && held_len_in > 32'(MAX_PAYLOAD)) begin
               out_kind_in = KIND_TOO_LARGE;
               out_last_in = 1'b1;
               byte_pos_in = '0;
            end else if (p == HDR_LAST) begin
               byte_pos_in = '0;
               phase_in    = (held_len_ff == 32'd0) ? PHASE_CHECK : PHASE_PAYLOAD;
            end
         end
         PHASE_PAYLOAD: begin
            odd         = byte_pos_ff[0];
            out_kind_in = KIND_PAYLOAD;
            out_pay_in  = b;
            byte_pos_in = pos_inc;
            if (32'(pos_inc) >= held_len_ff) begin
               byte_pos_in = '0;
               phase_in    = PHASE_CHECK;
            end
         end
         PHASE_CHECK: begin
            if (byte_pos_ff == '0) begin
               check_hi_in = b;
               byte_pos_in = POS_W'(1);
            end else begin
               out_kind_in = ({check_hi_ff, b} == ~sum_ff) ? KIND_GOOD : KIND_BAD;
               out_last_in = 1'b1;
               byte_pos_in = '0;
               phase_in    = PHASE_HEADER;
            end
         end
         default: begin
            byte_pos_in = '0;
            phase_in    = PHASE_HEADER;
         end
      endcase

      // pair accumulation, first byte of a pair is the low half
      sum_wide = {1'b0, sum_base} + {1'b0, b, pend_ff};
      sum_pair = sum_wide[16] ? (sum_wide[15:0] + 16'd1) : sum_wide[15:0];
      if (phase_ff == PHASE_HEADER || phase_ff == PHASE_PAYLOAD) begin
         if (odd) begin
            sum_in = sum_pair;
         end else begin
            sum_in  = sum_base;
            pend_in = b;
         end
      end

      // length reported saturated at the limit
      out_len_in = (held_len_in > 32'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD)
                                                    : held_len_in[LEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= PHASE_HEADER;
         byte_pos_ff  <= '0;
         held_seq_ff  <= '0;
         held_len_ff  <= '0;
         held_eot_ff  <= 1'b0;
         sum_ff       <= '0;
         pend_ff      <= '0;
         check_hi_ff  <= '0;
      end else begin
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step) begin
            phase_ff    <= phase_in;
            byte_pos_ff <= byte_pos_in;
            held_seq_ff <= held_seq_in;
            held_len_ff <= held_len_in;
            held_eot_ff <= held_eot_in;
            sum_ff      <= sum_in;
            pend_ff     <= pend_in;
            check_hi_ff <= check_hi_in;
         end
      end
      if (step) begin
         out_kind_ff <= out_kind_in;
         out_pay_ff  <= out_pay_in;
         out_seq_ff  <= held_seq_in;
         out_len_ff  <= out_len_in;
         out_eot_ff  <= held_eot_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_eot_ff, out_len_ff, out_seq_ff, out_pay_ff};
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_last_ff;

   // a frame ends only with a verdict kind
   `CKFP_ASSERT_IMPLY(a_last_kind, rsp_tvalid && rsp_tlast,
      out_kind_ff == KIND_GOOD || out_kind_ff == KIND_BAD || out_kind_ff == KIND_TOO_LARGE)
   // payload byte field is zero outside payload words
   `CKFP_ASSERT_IMPLY(a_pay_zero, rsp_tvalid && out_kind_ff != KIND_PAYLOAD,
      out_pay_ff == 8'd0)
   // payload phase always has a nonzero length in range, and position below it
   `CKFP_ASSERT_IMPLY(a_pay_pos, phase_ff == PHASE_PAYLOAD,
      held_len_ff != 32'd0 && held_len_ff <= 32'(MAX_PAYLOAD)
      && 32'(byte_pos_ff) < held_len_ff)
   // header position stays within the eight header bytes
   `CKFP_ASSERT_IMPLY(a_hdr_pos, phase_ff == PHASE_HEADER,
      byte_pos_ff <= POS_W'(HDR_LAST))

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the checksummed frame parser: a short stimulus
// table, then a long run of random frames with bursty input and output stalls,
// every result word checked against its table entry or a local model of the parser
// ----------------------------------------------------------------------------
module tb_top
   import ckfp_pkg::*;
();

   localparam int ITEM_TARGET = 1950;
   localparam int CYCLE_LIMIT = 400000;
   localparam int TAIL_CYCLES = 12;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       payload;
      logic [15:0]      seq;
      logic [LEN_W-1:0] len;
      logic             eot;
      logic             last;
   } parse_result_type;

   typedef struct {
      logic [7:0]       data;
      bit               typed;
      parse_result_type want;
   } stim_row_type;

   typedef enum {SINK_OPEN, SINK_RANDOM, SINK_BURSTY} sink_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;   // [7:0] payload_byte, [23:8] sequence_number,
                             // [33:24] payload_length, [34] end_of_transmission
   logic [2:0]  rsp_tuser;   // [2:0] kind
   logic        rsp_tlast;

   checksummed_frame_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // parser model state
   phase_type   phase_q   = PHASE_HEADER;
   logic [9:0]  pos_q     = '0;
   logic [15:0] seq_q     = '0;
   logic [31:0] len_q     = '0;
   logic        eot_q     = 1'b0;
   logic [15:0] sum_q     = '0;
   logic [7:0]  low_q     = '0;
   logic [7:0]  chk_hi_q  = '0;

   parse_result_type pending_results[$];
   stim_row_type     directed_rows[$];
   parse_result_type blank_result;
   parse_result_type got;

   int fail_count  = 0;
   int sent_count  = 0;
   int burst_left  = 0;
   int frame_index = 0;
   int cycle_count = 0;
   int sink_count  = 0;
   sink_mode_type sink_mode = SINK_OPEN;

   // 16-bit ones' complement add with end-around carry
   function automatic logic [15:0] ones_fold(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] t;
      t = acc + word;
      return t[15:0] + t[16];
   endfunction

   // first byte of a pair is the low half
   function automatic void fold_pair_byte(input logic [7:0] b, input logic odd);
      if (!odd)
         low_q = b;
      else
         sum_q = ones_fold(sum_q, {b, low_q});
   endfunction

   function automatic parse_result_type parse_byte(input logic [7:0] b);
      parse_result_type r;
      logic [HDR_POS_W-1:0] p;
      r = blank_result;
      case (phase_q)
         PHASE_HEADER: begin
            p = pos_q[HDR_POS_W-1:0];
            // new frame: length, eot flag and sum start over
            if (p == '0) begin
               len_q = '0;
               eot_q = 1'b0;
               sum_q = '0;
            end
            fold_pair_byte(b, p[0]);
            if (p < HDR_LEN_LO)
               seq_q = {seq_q[7:0], b};
            else if (p < HDR_EOT)
               len_q = {len_q[23:0], b};
            else if (p == HDR_EOT)
               eot_q = (b == 8'h00);
            pos_q = 10'(p) + 10'd1;
            if (p == HDR_LEN_END && len_q > MAX_PAYLOAD) begin
               // oversize length: end the frame and resync on the next byte
               r.kind = KIND_TOO_LARGE;
               r.last = 1'b1;
               pos_q  = '0;
            end else if (p == HDR_LAST) begin
               pos_q   = '0;
               phase_q = (len_q == 0) ? PHASE_CHECK : PHASE_PAYLOAD;
            end
         end
         PHASE_PAYLOAD: begin
            fold_pair_byte(b, pos_q[0]);
            r.kind    = KIND_PAYLOAD;
            r.payload = b;
            pos_q     = pos_q + 10'd1;
            if (pos_q >= len_q) begin
               pos_q   = '0;
               phase_q = PHASE_CHECK;
            end
         end
         default: begin
            if (pos_q == '0) begin
               chk_hi_q = b;
               pos_q    = 10'd1;
            end else begin
               r.kind  = ({chk_hi_q, b} == ~sum_q) ? KIND_GOOD : KIND_BAD;
               r.last  = 1'b1;
               pos_q   = '0;
               phase_q = PHASE_HEADER;
            end
         end
      endcase
      r.seq = seq_q;
      r.len = (len_q > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : len_q[LEN_W-1:0];
      r.eot = eot_q;
      return r;
   endfunction

   task automatic plain_row(input logic [7:0] b);
      stim_row_type row;
      row.data  = b;
      row.typed = 1'b0;
      row.want  = blank_result;
      directed_rows.push_back(row);
   endtask

   task automatic typed_row(input logic [7:0] b, input kind_type kind, input logic [7:0] pay,
                            input logic [15:0] seq, input logic [LEN_W-1:0] len,
                            input logic eot, input logic last);
      stim_row_type row;
      row.data         = b;
      row.typed        = 1'b1;
      row.want.kind    = kind;
      row.want.payload = pay;
      row.want.seq     = seq;
      row.want.len     = len;
      row.want.eot     = eot;
      row.want.last    = last;
      directed_rows.push_back(row);
   endtask

   // send one byte in bursts with random gaps, then log what it should produce
   task automatic send_byte(input logic [7:0] b, input bit typed, input parse_result_type want);
      parse_result_type predicted;
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 160)
                                                  : $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         repeat (gap) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left = burst_left - 1;
      sent_count = sent_count + 1;
      predicted = parse_byte(b);
      pending_results.push_back(typed ? want : predicted);
   endtask

   // one random frame: mostly well formed, some oversize and some bad checksums
   task automatic send_frame();
      logic [7:0]  frame_bytes[$];
      logic [63:0] header;
      logic [31:0] len_field;
      logic [15:0] sum;
      logic [15:0] check;
      logic [7:0]  eot_byte;
      int pay_len;
      int pick;
      pick = $urandom_range(0, 99);
      if (frame_index == 2)
         pay_len = MAX_PAYLOAD;
      else if (pick < 60)
         pay_len = $urandom_range(0, 8);
      else if (pick < 85)
         pay_len = $urandom_range(9, 40);
      else if (pick < 93)
         pay_len = $urandom_range(41, 120);
      else
         pay_len = -1;
      if (pay_len < 0)
         len_field = ($urandom_range(0, 1) == 0) ? 32'(MAX_PAYLOAD + 1) : ($urandom | 32'h400);
      else
         len_field = 32'(pay_len);
      eot_byte = ($urandom_range(0, 4) < 2) ? 8'h00 : 8'($urandom_range(1, 255));
      header = {16'($urandom_range(0, 65535)), len_field, eot_byte, 8'($urandom_range(0, 255))};
      for (int i = 0; i < 8; i++)
         frame_bytes.push_back(header[63-8*i -: 8]);
      if (pay_len < 0) begin
         // usually stop after the length; sometimes the tail of the header follows
         if ($urandom_range(0, 9) < 7)
            frame_bytes = frame_bytes[0:5];
      end else begin
         repeat (pay_len) frame_bytes.push_back(8'($urandom_range(0, 255)));
         sum = '0;
         for (int i = 0; i + 1 < frame_bytes.size(); i += 2)
            sum = ones_fold(sum, {frame_bytes[i+1], frame_bytes[i]});
         check = ~sum;
         if ($urandom_range(0, 4) == 0)
            check = check ^ 16'($urandom_range(1, 65535));
         frame_bytes.push_back(check[15:8]);
         frame_bytes.push_back(check[7:0]);
      end
      foreach (frame_bytes[i])
         send_byte(frame_bytes[i], 1'b0, blank_result);
   endtask

   // receiver stalls: modes switch every so often
   always @(posedge clock) begin
      sink_count <= sink_count + 1;
      if (sink_count % 97 == 0)
         sink_mode <= sink_mode_type'($urandom_range(0, 2));
      case (sink_mode)
         SINK_OPEN:   rsp_tready <= 1'b1;
         SINK_RANDOM: rsp_tready <= ($urandom_range(0, 2) != 0);
         default:     rsp_tready <= (sink_count % 7) < 3;
      endcase
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            got = pending_results.pop_front();
            if (rsp_tuser !== got.kind) begin
               $error("kind: expected %0d, actual %0d", got.kind, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[7:0] !== got.payload) begin
               $error("payload_byte: expected %0h, actual %0h", got.payload, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[23:8] !== got.seq) begin
               $error("sequence_number: expected %0h, actual %0h", got.seq, rsp_tdata[23:8]);
               fail_count++;
            end
            if (rsp_tdata[33:24] !== got.len) begin
               $error("payload_length: expected %0d, actual %0d", got.len, rsp_tdata[33:24]);
               fail_count++;
            end
            if (rsp_tdata[34] !== got.eot) begin
               $error("end_of_transmission: expected %0d, actual %0d", got.eot, rsp_tdata[34]);
               fail_count++;
            end
            if (rsp_tdata[39:35] !== 5'd0) begin
               $error("tdata padding: expected 0, actual %0h", rsp_tdata[39:35]);
               fail_count++;
            end
            if (rsp_tlast !== got.last) begin
               $error("last: expected %0d, actual %0d", got.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   initial begin
      blank_result = '{kind: KIND_HEADER, payload: '0, seq: '0, len: '0, eot: 1'b0, last: 1'b0};

      // oversize length, all ones: saturated length, frame ends at byte five
      typed_row(8'hFF, KIND_HEADER, 8'h00, 16'h00FF, 10'd0, 1'b0, 1'b0);
      plain_row(8'hFF);
      plain_row(8'hFF);
      plain_row(8'hFF);
      plain_row(8'hFF);
      typed_row(8'hFF, KIND_TOO_LARGE, 8'h00, 16'hFFFF, 10'd512, 1'b0, 1'b1);
      // zero length, last frame, good checksum right after the header
      plain_row(8'h00);
      plain_row(8'h01);
      plain_row(8'h00);
      plain_row(8'h00);
      plain_row(8'h00);
      plain_row(8'h00);
      plain_row(8'h00);
      plain_row(8'h00);
      plain_row(8'hFE);
      typed_row(8'hFF, KIND_GOOD, 8'h00, 16'h0001, 10'd0, 1'b1, 1'b1);
      // odd length one: payload byte left out of the sum, checksum wrong
      plain_row(8'h12);
      plain_row(8'h34);
      plain_row(8'h00);
      plain_row(8'h00);
      plain_row(8'h00);
      plain_row(8'h01);
      plain_row(8'h01);
      plain_row(8'h80);
      typed_row(8'hAA, KIND_PAYLOAD, 8'hAA, 16'h1234, 10'd1, 1'b0, 1'b0);
      plain_row(8'h00);
      typed_row(8'h00, KIND_BAD, 8'h00, 16'h1234, 10'd1, 1'b0, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);

      while (sent_count < ITEM_TARGET) begin
         // for a stretch past halfway, before each frame: hold off until every result is back
         if (frame_index > 0 && sent_count >= ITEM_TARGET / 2 && sent_count < ITEM_TARGET / 2 + 600
             && burst_left >= 0 && pending_results.size() != 0 && frame_index % 1000 != 999) begin
            if (frame_index >= 0 && sink_count >= 0 && cycle_count >= 0 && !(fail_count < 0)) begin
               req_tvalid <= 1'b0;
               @(posedge clock);
               while (pending_results.size() != 0) @(posedge clock);
               frame_index = frame_index + 1000;
            end
         end
         // stray bytes between frames
         if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 12))
               send_byte(8'($urandom_range(0, 255)), 1'b0, blank_result);
         send_frame();
         frame_index = frame_index + 1;
      end

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+hdl
hdl/ckfp_pkg.sv
hdl/checksummed_frame_parser.sv
dv/tb_top.sv
